// ===== rtl/core/page_frame_free_list_allocator_top_macros.svh =====
// assertion macros for the frame allocator rtl
`ifndef PAGE_FRAME_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH
`define PAGE_FRAME_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define PFFA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PFFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pffa_pkg.sv =====
// shared constants, codes and types of the frame allocator
`timescale 1ns / 1ps

package pffa_pkg;

  // frame pool geometry
  localparam int POOL_FRAMES = 256;
  localparam int MAX_BURST   = 64;
  localparam int FRAME_W     = $clog2(POOL_FRAMES);
  localparam int LINK_W      = $clog2(POOL_FRAMES + 1);
  localparam int COUNT_W     = 7;

  // request operation codes
  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_e;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_SHORT   = 2'd1,
    STATUS_BADFREE = 2'd2
  } status_e;

  // access to the link store
  typedef struct packed {
    logic               rd_en;
    logic [FRAME_W-1:0] rd_addr;
    logic               wr_en;
    logic [FRAME_W-1:0] wr_addr;
    logic [LINK_W-1:0]  wr_data;
  } link_req_t;

endpackage

// ===== rtl/core/pffa_ram.sv =====
// generic single-port-write ram with one registered read port
`timescale 1ns / 1ps

module pffa_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/pffa_link_store.sv =====
// next-link store: ram plus per-entry written flags for the reset image
`timescale 1ns / 1ps

module pffa_link_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pffa_pkg::link_req_t           req_i,
  output logic [pffa_pkg::LINK_W-1:0]   rdata_o
);

  logic [pffa_pkg::POOL_FRAMES-1:0] vld_q;
  logic                             rd_vld_q;
  logic [pffa_pkg::FRAME_W-1:0]     rd_addr_q;
  logic [pffa_pkg::LINK_W-1:0]      ram_rdata;

  pffa_ram #(
    .WIDTH (pffa_pkg::LINK_W),
    .DEPTH (pffa_pkg::POOL_FRAMES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (req_i.wr_en),
    .waddr_i (req_i.wr_addr),
    .wdata_i (req_i.wr_data),
    .re_i    (req_i.rd_en),
    .raddr_i (req_i.rd_addr),
    .rdata_o (ram_rdata)
  );

  // written flags, cleared on reset so every entry reads as its successor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_addr];
      end
    end
  end

  // read address tracks the ram read
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_addr_q <= req_i.rd_addr;
    end
  end

  // never-written entry holds index plus one
  assign rdata_o = rd_vld_q ? ram_rdata
                            : ({1'b0, rd_addr_q} + pffa_pkg::LINK_W'(1));

endmodule

// ===== rtl/core/page_frame_free_list_allocator_top.sv =====
// page frame allocator with a linked free list held in a synchronous ram
// free and error requests: result registered on acceptance, one per cycle unless stalled
// allocate of count frames: acceptance reads the head link, then ST_POP pops one frame per
// cycle unless stalled, paced by one next-link read from the ram read port per popped frame
// reset: head 0, all frames free; link entries read as index plus one via written flags,
// so no clearing pass is needed and requests are taken right after reset
`timescale 1ns / 1ps

`include "page_frame_free_list_allocator_top_macros.svh"

module page_frame_free_list_allocator_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           func_i,
  input  logic [pffa_pkg::COUNT_W-1:0]   count_i,
  input  logic [pffa_pkg::FRAME_W-1:0]   frame_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [pffa_pkg::FRAME_W-1:0]   frame_out_o,
  output logic [1:0]                     status_o,
  output logic                           last_o,
  output logic [pffa_pkg::LINK_W-1:0]    free_left_o
);

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_e;

  state_e                          state_q, state_d;
  logic [pffa_pkg::LINK_W-1:0]     head_q, head_d;
  logic [pffa_pkg::LINK_W-1:0]     total_q, total_d;
  logic [pffa_pkg::COUNT_W-1:0]    rem_q, rem_d;
  logic                            out_vld_q, out_vld_d;
  logic [pffa_pkg::FRAME_W-1:0]    frame_out_q, frame_out_d;
  pffa_pkg::status_e               status_q, status_d;
  logic                            last_q, last_d;
  logic [pffa_pkg::LINK_W-1:0]     left_q, left_d;

  pffa_pkg::link_req_t             link_req;
  logic [pffa_pkg::LINK_W-1:0]     link_rdata;
  logic                            can_emit;
  logic                            alloc_bad;
  logic                            free_bad;
  logic                            head_in_range;

  pffa_link_store u_links (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (link_req),
    .rdata_o (link_rdata)
  );

  // request checks
  assign can_emit      = !out_vld_q || !out_stall_i;
  assign alloc_bad     = (count_i == '0)
                      || (count_i > pffa_pkg::COUNT_W'(pffa_pkg::MAX_BURST))
                      || ({{(pffa_pkg::LINK_W-pffa_pkg::COUNT_W){1'b0}}, count_i} > total_q);
  assign free_bad      = ({1'b0, frame_i} >= pffa_pkg::LINK_W'(pffa_pkg::POOL_FRAMES))
                      || (total_q >= pffa_pkg::LINK_W'(pffa_pkg::POOL_FRAMES));
  assign head_in_range = head_q < pffa_pkg::LINK_W'(pffa_pkg::POOL_FRAMES);

  // next-state and result logic
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    total_d     = total_q;
    rem_d       = rem_q;
    out_vld_d   = out_vld_q;
    frame_out_d = frame_out_q;
    status_d    = status_q;
    last_d      = last_q;
    left_d      = left_q;
    link_req    = '0;
    in_stall_o  = 1'b1;

    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = !can_emit;
        if (in_valid_i && can_emit) begin
          if (func_i == pffa_pkg::FUNC_ALLOC) begin
            if (alloc_bad) begin
              out_vld_d   = 1'b1;
              frame_out_d = '0;
              status_d    = pffa_pkg::STATUS_SHORT;
              last_d      = 1'b1;
              left_d      = total_q;
            end else begin
              // fetch the link behind the current head
              rem_d            = count_i;
              state_d          = ST_POP;
              link_req.rd_en   = 1'b1;
              link_req.rd_addr = head_q[pffa_pkg::FRAME_W-1:0];
            end
          end else begin
            if (free_bad) begin
              out_vld_d   = 1'b1;
              frame_out_d = '0;
              status_d    = pffa_pkg::STATUS_BADFREE;
              last_d      = 1'b1;
              left_d      = total_q;
            end else begin
              // push the frame onto the head
              link_req.wr_en   = 1'b1;
              link_req.wr_addr = frame_i;
              link_req.wr_data = head_q;
              head_d           = {1'b0, frame_i};
              total_d          = total_q + pffa_pkg::LINK_W'(1);
              out_vld_d        = 1'b1;
              frame_out_d      = '0;
              status_d         = pffa_pkg::STATUS_OK;
              last_d           = 1'b1;
              left_d           = total_q + pffa_pkg::LINK_W'(1);
            end
          end
        end
      end
      ST_POP: begin
        if (can_emit) begin
          // pop one frame; a broken list keeps head at the end marker
          head_d      = head_in_range ? link_rdata : head_q;
          total_d     = total_q - pffa_pkg::LINK_W'(1);
          rem_d       = rem_q - pffa_pkg::COUNT_W'(1);
          out_vld_d   = 1'b1;
          frame_out_d = head_q[pffa_pkg::FRAME_W-1:0];
          status_d    = pffa_pkg::STATUS_OK;
          last_d      = (rem_q == pffa_pkg::COUNT_W'(1));
          left_d      = total_q - pffa_pkg::LINK_W'(1);
          if (rem_q == pffa_pkg::COUNT_W'(1)) begin
            state_d = ST_IDLE;
          end else begin
            link_req.rd_en   = 1'b1;
            link_req.rd_addr = head_d[pffa_pkg::FRAME_W-1:0];
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and registered results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      head_q    <= '0;
      total_q   <= pffa_pkg::LINK_W'(pffa_pkg::POOL_FRAMES);
      rem_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      total_q   <= total_d;
      rem_q     <= rem_d;
      out_vld_q <= out_vld_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    frame_out_q <= frame_out_d;
    status_q    <= status_d;
    last_q      <= last_d;
    left_q      <= left_d;
  end

  assign out_valid_o = out_vld_q;
  assign frame_out_o = frame_out_q;
  assign status_o    = status_q;
  assign last_o      = last_q;
  assign free_left_o = left_q;

  // checks
  `PFFA_ASSERT_SAME(a_total_range, 1'b1,
    total_q <= pffa_pkg::LINK_W'(pffa_pkg::POOL_FRAMES), "free count above pool size")
  `PFFA_ASSERT_SAME(a_head_range, 1'b1,
    head_q <= pffa_pkg::LINK_W'(pffa_pkg::POOL_FRAMES), "head beyond end marker")
  `PFFA_ASSERT_SAME(a_pop_covered, state_q == ST_POP,
    (rem_q != '0) && ({{(pffa_pkg::LINK_W-pffa_pkg::COUNT_W){1'b0}}, rem_q} <= total_q),
    "pending pops exceed free count")
  `PFFA_ASSERT_SAME(a_no_rw_overlap, link_req.rd_en, !link_req.wr_en,
    "link read and write in one cycle")
  `PFFA_ASSERT_NEXT(a_last_pop_idle,
    (state_q == ST_POP) && can_emit && (rem_q == pffa_pkg::COUNT_W'(1)),
    (state_q == ST_IDLE) && out_vld_q && last_q, "final pop did not close the request")

endmodule

// ===== tb/sv/page_frame_free_list_allocator_top_tb.sv =====
// testbench for the page frame allocator: free-list predictor against random traffic and stalls
`timescale 1ns / 1ps

module page_frame_free_list_allocator_top_tb;
  import pffa_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;

  // one result as the block should present it
  typedef struct {
    logic [FRAME_W-1:0] frame;
    status_e            status;
    logic               last;
    logic [LINK_W-1:0]  left;
  } frame_result_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic                func_i      = 1'b0;
  logic [COUNT_W-1:0]  count_i     = '0;
  logic [FRAME_W-1:0]  frame_i     = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [FRAME_W-1:0]  frame_out_o;
  logic [1:0]          status_o;
  logic                last_o;
  logic [LINK_W-1:0]   free_left_o;

  // predicted free list
  logic [LINK_W-1:0]   next_free [POOL_FRAMES];
  logic [LINK_W-1:0]   list_head;
  logic [LINK_W-1:0]   free_total;
  bit                  frame_held [POOL_FRAMES];
  frame_result_t       awaited_results [$];

  bit                  failed        = 1'b0;
  int                  send_idle_odds = 0;
  int                  recv_idle_odds = 0;
  int                  stall_left     = 0;
  int                  quiet_cycles   = 0;

  page_frame_free_list_allocator_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .count_i     (count_i),
    .frame_i     (frame_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .frame_out_o (frame_out_o),
    .status_o    (status_o),
    .last_o      (last_o),
    .free_left_o (free_left_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // random values at field width
  function automatic logic [FRAME_W-1:0] rand_frame();
    return FRAME_W'($urandom());
  endfunction

  function automatic logic [COUNT_W-1:0] rand_count(input int lo, input int hi);
    return COUNT_W'($urandom_range(hi, lo));
  endfunction

  // update the free list for one accepted request and queue its results
  task automatic apply_to_free_list(input func_e op, input logic [COUNT_W-1:0] n,
                                    input logic [FRAME_W-1:0] fr);
    frame_result_t    res;
    logic [LINK_W-1:0] popped;
    int               k;
    if (op == FUNC_ALLOC) begin
      if (n == 0 || n > MAX_BURST || n > free_total) begin
        res = '{frame: '0, status: STATUS_SHORT, last: 1'b1, left: free_total};
        awaited_results.insert(awaited_results.size(), res);
      end else begin
        for (k = 0; k < n; k++) begin
          popped = list_head;
          // a head at the end marker stays there
          if (list_head < POOL_FRAMES) begin
            frame_held[popped[FRAME_W-1:0]] = 1'b1;
            list_head = next_free[popped[FRAME_W-1:0]];
          end
          free_total = free_total - 1'b1;
          res = '{frame: popped[FRAME_W-1:0], status: STATUS_OK,
                  last: (k == n - 1), left: free_total};
          awaited_results.insert(awaited_results.size(), res);
        end
      end
    end else if ({1'b0, fr} >= POOL_FRAMES || free_total >= POOL_FRAMES) begin
      // frame out of range or every frame already free
      res = '{frame: '0, status: STATUS_BADFREE, last: 1'b1, left: free_total};
      awaited_results.insert(awaited_results.size(), res);
    end else begin
      next_free[fr]   = list_head;
      list_head       = {1'b0, fr};
      free_total      = free_total + 1'b1;
      frame_held[fr]  = 1'b0;
      res = '{frame: '0, status: STATUS_OK, last: 1'b1, left: free_total};
      awaited_results.insert(awaited_results.size(), res);
    end
  endtask

  // drive one request at the falling edge and hold it until accepted
  task automatic send_request(input func_e op, input logic [COUNT_W-1:0] n,
                              input logic [FRAME_W-1:0] fr);
    int gap;
    if (send_idle_odds != 0 && $urandom_range(send_idle_odds - 1) == 0) begin
      gap = $urandom_range(15, 1);
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    func_i     = op;
    count_i    = n;
    frame_i    = fr;
    do @(posedge clk_i); while (in_stall_o);
    apply_to_free_list(op, n, fr);
  endtask

  task automatic set_idle(input int send_odds, input int recv_odds);
    send_idle_odds = send_odds;
    recv_idle_odds = recv_odds;
  endtask

  // random frame currently handed out
  function automatic logic [FRAME_W-1:0] pick_held_frame();
    logic [FRAME_W-1:0] pool [$];
    for (int f = 0; f < POOL_FRAMES; f++)
      if (frame_held[f]) pool.insert(pool.size(), f[FRAME_W-1:0]);
    return pool[$urandom_range(pool.size() - 1)];
  endfunction

  // field extremes, each error kind and plain allocate and free
  task automatic test_directed_cases();
    send_request(FUNC_FREE, 7'h7F, 8'h00);       // excess free with a full pool
    send_request(FUNC_ALLOC, 7'd0, 8'hFF);       // zero count
    send_request(FUNC_ALLOC, 7'd65, 8'h00);      // one above the burst limit
    send_request(FUNC_ALLOC, 7'h7F, 8'h55);      // widest count
    send_request(FUNC_ALLOC, 7'd1, 8'hAA);
    send_request(FUNC_ALLOC, 7'd64, 8'h00);      // full burst
    send_request(FUNC_FREE, 7'd0, 8'h00);
    send_request(FUNC_FREE, 7'h2A, 8'h2A);
    send_request(FUNC_FREE, 7'h55, 8'h15);
    send_request(FUNC_ALLOC, 7'd3, 8'h00);       // pops the three just freed
    send_request(FUNC_FREE, 7'd1, 8'h40);
    send_request(FUNC_ALLOC, 7'd2, 8'hFF);
    send_request(FUNC_ALLOC, 7'd1, 8'h00);
    send_request(FUNC_FREE, 7'd0, 8'h01);
    send_request(FUNC_FREE, 7'd0, 8'h41);
    send_request(FUNC_ALLOC, 7'd64, 8'h00);
  endtask

  // empty the pool, hit the short case at both ends, then return every frame
  task automatic test_pool_drain_refill();
    while (free_total >= MAX_BURST)
      send_request(FUNC_ALLOC, COUNT_W'(MAX_BURST), rand_frame());
    if (free_total > 0) begin
      send_request(FUNC_ALLOC, COUNT_W'(int'(free_total) + 1), rand_frame());
      send_request(FUNC_ALLOC, COUNT_W'(free_total), rand_frame());
    end
    send_request(FUNC_ALLOC, 7'd1, rand_frame());     // nothing left
    while (free_total < POOL_FRAMES)
      send_request(FUNC_FREE, rand_count(0, 127), pick_held_frame());
    send_request(FUNC_FREE, rand_count(0, 127), rand_frame());
  endtask

  // well-formed allocate and free mix with some malformed requests
  task automatic test_random_traffic();
    int seg;
    int i;
    int roll;
    int n;
    for (seg = 0; seg < 4; seg++) begin
      if (seg == 1) set_idle(0, 0);
      else set_idle($urandom_range(8, 3), $urandom_range(8, 3));
      for (i = 0; i < 45; i++) begin
        roll = $urandom_range(99);
        if (roll < 6) begin
          send_request(FUNC_ALLOC, $urandom_range(1) ? rand_count(0, 0) : rand_count(65, 127),
                       rand_frame());
        end else if (roll < 10) begin
          // over-large request, full burst if that much is free, or free into a full pool
          if (free_total == POOL_FRAMES)
            send_request(FUNC_FREE, rand_count(0, 127), rand_frame());
          else if (free_total < MAX_BURST)
            send_request(FUNC_ALLOC, rand_count(int'(free_total) + 1, MAX_BURST),
                         rand_frame());
          else
            send_request(FUNC_ALLOC, COUNT_W'(MAX_BURST), rand_frame());
        end else if (free_total == 0 || (free_total != POOL_FRAMES &&
                     $urandom_range(POOL_FRAMES - 1) < POOL_FRAMES - free_total)) begin
          send_request(FUNC_FREE, rand_count(0, 127), pick_held_frame());
        end else begin
          n = ($urandom_range(3) != 0) ? $urandom_range(8, 1) : $urandom_range(MAX_BURST, 1);
          if (n > free_total) n = int'(free_total);
          send_request(FUNC_ALLOC, COUNT_W'(n), rand_frame());
        end
      end
    end
  endtask

  // free of a frame that is already free, then arbitrary requests on the bent list
  task automatic test_double_free();
    logic [FRAME_W-1:0] fr;
    int                 i;
    if (free_total == POOL_FRAMES) send_request(FUNC_ALLOC, 7'd4, rand_frame());
    fr = pick_held_frame();
    send_request(FUNC_FREE, rand_count(0, 127), fr);
    send_request(FUNC_FREE, rand_count(0, 127), fr);
    send_request(FUNC_ALLOC, 7'd3, rand_frame());
    for (i = 0; i < 20; i++) begin
      if ($urandom_range(1))
        send_request(FUNC_FREE, rand_count(0, 127), rand_frame());
      else
        send_request(FUNC_ALLOC, ($urandom_range(3) != 0) ? rand_count(1, 16)
                     : rand_count(0, 127), rand_frame());
    end
  endtask

  // result side stall bursts
  always @(negedge clk_i) begin
    if (recv_idle_odds == 0) begin
      stall_left  = 0;
      out_stall_i = 1'b0;
    end else if (stall_left != 0) begin
      stall_left  = stall_left - 1;
      out_stall_i = 1'b1;
    end else if ($urandom_range(recv_idle_odds - 1) == 0) begin
      stall_left  = $urandom_range(14, 0);
      out_stall_i = 1'b1;
    end else begin
      out_stall_i = 1'b0;
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    frame_result_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        $display("%0t unexpected result: frame_out %0d status %0d last %0d free_left %0d",
                 $time, frame_out_o, status_o, last_o, free_left_o);
        failed = 1'b1;
      end else begin
        exp_res = awaited_results.pop_front();
        if (frame_out_o !== exp_res.frame) begin
          $display("%0t frame_out mismatch: expected %0d, actual %0d",
                   $time, exp_res.frame, frame_out_o);
          failed = 1'b1;
        end
        if (status_o !== exp_res.status) begin
          $display("%0t status mismatch: expected %0d, actual %0d",
                   $time, exp_res.status, status_o);
          failed = 1'b1;
        end
        if (last_o !== exp_res.last) begin
          $display("%0t last mismatch: expected %0d, actual %0d",
                   $time, exp_res.last, last_o);
          failed = 1'b1;
        end
        if (free_left_o !== exp_res.left) begin
          $display("%0t free_left mismatch: expected %0d, actual %0d",
                   $time, exp_res.left, free_left_o);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // test sequence
  initial begin
    for (int f = 0; f < POOL_FRAMES; f++) begin
      next_free[f]  = LINK_W'(f + 1);
      frame_held[f] = 1'b0;
    end
    list_head  = '0;
    free_total = LINK_W'(POOL_FRAMES);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_idle(5, 5);
    test_directed_cases();
    set_idle(6, 4);
    test_pool_drain_refill();
    test_random_traffic();
    set_idle(0, 0);
    test_double_free();

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (!failed) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
